// ===== design/wud_pkg.sv =====
`timescale 1ns / 1ps

package wud_pkg;

    localparam int LIMB_W    = 64;
    localparam int PORT_LIMBS = 5;
    localparam int NUM_LIMBS = 5;
    localparam int DIV_W     = NUM_LIMBS * LIMB_W;
    localparam int CNT_W     = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } wud_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic ready;
        logic done;
    } wud_ctrl_t;

endpackage

// ===== design/wud_step.sv =====
`timescale 1ns / 1ps

module wud_step (
    input  logic [wud_pkg::DIV_W-1:0] rem,
    input  logic [wud_pkg::DIV_W-1:0] num,
    input  logic [wud_pkg::DIV_W-1:0] den,
    output logic [wud_pkg::DIV_W-1:0] rem_next,
    output logic [wud_pkg::DIV_W-1:0] num_next
);

    // shifted partial remainder carries one extra top bit
    logic [wud_pkg::DIV_W:0]   shifted;
    logic [wud_pkg::DIV_W+1:0] diff;
    logic                      take;

    always_comb
    begin
        shifted  = {rem, num[wud_pkg::DIV_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den};
        take     = ~diff[wud_pkg::DIV_W+1];
        rem_next = take ? diff[wud_pkg::DIV_W-1:0] : shifted[wud_pkg::DIV_W-1:0];
        // quotient bits enter at the bottom as dividend bits leave the top
        num_next = {num[wud_pkg::DIV_W-2:0], take};
    end

endmodule

// ===== design/wud_seq.sv =====
`timescale 1ns / 1ps

module wud_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_ready,
    input  logic               den_zero,
    output wud_pkg::wud_ctrl_t ctrl
);

    wud_pkg::wud_state_t         state_reg, state_next;
    logic [wud_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.ready = 1'b0;
        ctrl.done  = 1'b0;
        unique case (state_reg)
            wud_pkg::ST_IDLE:
            begin
                ctrl.ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = wud_pkg::CNT_W'(wud_pkg::DIV_W - 1);
                    state_next = den_zero ? wud_pkg::ST_DONE : wud_pkg::ST_RUN;
                end
            end
            wud_pkg::ST_RUN:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = wud_pkg::ST_DONE;
                end
            end
            wud_pkg::ST_DONE:
            begin
                ctrl.done = 1'b1;
                if (out_ready)
                begin
                    state_next = wud_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wud_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wud_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/wide_unsigned_divider_core.sv =====
`timescale 1ns / 1ps
// After a request is accepted the shared shift-subtract unit processes one dividend bit per
// cycle (a zero divisor goes straight to done); the result is held until taken.
// A new request is accepted only once the previous result has been taken;
// not ready while busy.
// Reset (rst_n, async, active low) returns the sequencer to idle; datapath
// registers are not reset.

module wide_unsigned_divider_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [63:0] dividend_limb0,
    input  logic [63:0] dividend_limb1,
    input  logic [63:0] dividend_limb2,
    input  logic [63:0] dividend_limb3,
    input  logic [63:0] dividend_limb4,
    input  logic [63:0] divisor_limb0,
    input  logic [63:0] divisor_limb1,
    input  logic [63:0] divisor_limb2,
    input  logic [63:0] divisor_limb3,
    input  logic [63:0] divisor_limb4,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_limb0,
    output logic [63:0] result_limb1,
    output logic [63:0] result_limb2,
    output logic [63:0] result_limb3,
    output logic [63:0] result_limb4,
    output logic        divide_by_zero
);

    logic [wud_pkg::LIMB_W-1:0] num_in [wud_pkg::PORT_LIMBS];
    logic [wud_pkg::LIMB_W-1:0] den_in [wud_pkg::PORT_LIMBS];
    logic [wud_pkg::LIMB_W-1:0] res_out [wud_pkg::PORT_LIMBS];

    logic [wud_pkg::DIV_W-1:0] num_wide, den_wide, res_wide;
    logic [wud_pkg::DIV_W-1:0] num_reg, den_reg, rem_reg;
    logic [wud_pkg::DIV_W-1:0] num_step, rem_step;
    logic                      mode_reg, dz_reg;
    logic                      den_zero;
    wud_pkg::wud_ctrl_t        ctrl;

    assign num_in[0] = dividend_limb0;
    assign num_in[1] = dividend_limb1;
    assign num_in[2] = dividend_limb2;
    assign num_in[3] = dividend_limb3;
    assign num_in[4] = dividend_limb4;
    assign den_in[0] = divisor_limb0;
    assign den_in[1] = divisor_limb1;
    assign den_in[2] = divisor_limb2;
    assign den_in[3] = divisor_limb3;
    assign den_in[4] = divisor_limb4;

    genvar gi;
    generate
        for (gi = 0; gi < wud_pkg::NUM_LIMBS; gi++)
        begin : g_pack
            assign num_wide[gi*wud_pkg::LIMB_W +: wud_pkg::LIMB_W] = num_in[gi];
            assign den_wide[gi*wud_pkg::LIMB_W +: wud_pkg::LIMB_W] = den_in[gi];
        end
        for (gi = 0; gi < wud_pkg::PORT_LIMBS; gi++)
        begin : g_unpack
            if (gi < wud_pkg::NUM_LIMBS)
            begin : g_used
                assign res_out[gi] = res_wide[gi*wud_pkg::LIMB_W +: wud_pkg::LIMB_W];
            end
            else
            begin : g_unused
                assign res_out[gi] = '0;
            end
        end
    endgenerate

    assign den_zero = (den_wide == '0);

    wud_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .den_zero  (den_zero),
        .ctrl      (ctrl)
    );

    wud_step u_step (
        .rem      (rem_reg),
        .num      (num_reg),
        .den      (den_reg),
        .rem_next (rem_step),
        .num_next (num_step)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            num_reg  <= num_wide;
            den_reg  <= den_wide;
            rem_reg  <= '0;
            mode_reg <= mode;
            dz_reg   <= den_zero;
        end
        else if (ctrl.step)
        begin
            num_reg <= num_step;
            rem_reg <= rem_step;
        end
    end

    // num_reg holds the quotient once all bits are shifted through
    assign res_wide = dz_reg ? '0 : (mode_reg ? rem_reg : num_reg);

    assign in_ready       = ctrl.ready;
    assign out_valid      = ctrl.done;
    assign result_limb0   = res_out[0];
    assign result_limb1   = res_out[1];
    assign result_limb2   = res_out[2];
    assign result_limb3   = res_out[3];
    assign result_limb4   = res_out[4];
    assign divide_by_zero = dz_reg;

endmodule
